>>> sv/plir_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the positional list block
// no dependencies; every other file imports this package
package plir_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 7;
  localparam int STAT_W    = 2;
  localparam int COUNT_W   = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // memory read address source
  typedef enum logic [1:0] {
    RD_POS  = 2'd0,
    RD_PREV = 2'd1,
    RD_NEXT = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    load_req;
    logic    stat_load;
    logic    idx_from_count;
    logic    idx_from_pos;
    logic    idx_inc;
    logic    idx_dec;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_from_val;
    logic    take_removed;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
  } plir_cmd_t;

  typedef struct packed {
    logic is_remove;
    logic err;
    logic more;
  } plir_stat_t;

endpackage

>>> sv/plir_ifs.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for request and result beats
// depends on plir_pkg
interface plir_in_if;
  import plir_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic signed [VAL_W-1:0] item_value;
  logic [POS_W-1:0]        position;

  modport source (output valid, output operation, output item_value, output position,
                  input ready);
  modport sink   (input valid, input operation, input item_value, input position,
                  output ready);
endinterface

interface plir_out_if;
  import plir_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] removed_value;
  logic [STAT_W-1:0]       status;
  logic [COUNT_W-1:0]      element_count;

  modport source (output valid, output removed_value, output status, output element_count,
                  input ready);
  modport sink   (input valid, input removed_value, input status, input element_count,
                  output ready);
endinterface

>>> sv/plir_datapath.sv
`timescale 1ns / 1ps
// datapath: element memory, count, shift index, request and result registers
// depends on plir_pkg; driven by plir_ctrl commands
module plir_datapath #(
  parameter int DEPTH = plir_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  plir_pkg::plir_cmd_t               cmd,
  output plir_pkg::plir_stat_t              stat,
  input  logic                              in_operation,
  input  logic signed [plir_pkg::VAL_W-1:0] in_item_value,
  input  logic [plir_pkg::POS_W-1:0]        in_position,
  output logic signed [plir_pkg::VAL_W-1:0] out_removed_value,
  output logic [plir_pkg::STAT_W-1:0]       out_status,
  output logic [plir_pkg::COUNT_W-1:0]      out_element_count
);
  import plir_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic signed [VAL_W-1:0] mem [DEPTH];

  logic                    op_r;
  logic signed [VAL_W-1:0] val_r;
  logic [POS_W-1:0]        pos_r;
  logic [CNT_W-1:0]        count_r;
  logic [ADDR_W-1:0]       idx_r;
  logic signed [VAL_W-1:0] rdata_r;
  logic signed [VAL_W-1:0] removed_r;
  status_t                 status_r;
  logic signed [VAL_W-1:0] out_removed_r;
  status_t                 out_status_r;
  logic [COUNT_W-1:0]      out_count_r;

  status_t                 status_nxt;
  logic [ADDR_W-1:0]       rd_addr;
  logic signed [VAL_W-1:0] wr_data;
  logic [CMP_W-1:0]        pos_ext;
  logic [CMP_W-1:0]        cnt_ext;
  logic [CMP_W-1:0]        idx_ext;

  assign pos_ext = CMP_W'(pos_r);
  assign cnt_ext = CMP_W'(count_r);
  assign idx_ext = CMP_W'(idx_r);

  // full check wins over the position check on insert
  always_comb begin
    status_nxt = ST_OK;
    if (op_r == OP_INSERT) begin
      priority if (count_r == CNT_W'(DEPTH)) status_nxt = ST_FULL;
      else if (pos_ext > cnt_ext)             status_nxt = ST_RANGE;
      else                                    status_nxt = ST_OK;
    end else begin
      if (pos_ext >= cnt_ext) status_nxt = ST_RANGE;
    end
  end

  assign stat.is_remove = (op_r == OP_REMOVE);
  assign stat.err       = (status_nxt != ST_OK);
  // insert walks down toward pos, remove walks up toward count-1
  assign stat.more      = (op_r == OP_REMOVE) ? ((idx_ext + CMP_W'(1)) < cnt_ext)
                                              : (idx_ext > pos_ext);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_POS:  rd_addr = ADDR_W'(pos_r);
      RD_PREV: rd_addr = idx_r - ADDR_W'(1);
      RD_NEXT: rd_addr = idx_r + ADDR_W'(1);
      default: rd_addr = idx_r;
    endcase
  end

  assign wr_data = cmd.wr_from_val ? val_r : rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[idx_r] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r      <= in_operation;
      val_r     <= in_item_value;
      pos_r     <= in_position;
      removed_r <= '0;
    end
    if (cmd.take_removed) begin
      removed_r <= rdata_r;
    end
    if (cmd.stat_load) begin
      status_r <= status_nxt;
    end
    priority if (cmd.idx_from_count) idx_r <= ADDR_W'(count_r);
    else if (cmd.idx_from_pos)        idx_r <= ADDR_W'(pos_r);
    else if (cmd.idx_inc)             idx_r <= idx_r + ADDR_W'(1);
    else if (cmd.idx_dec)             idx_r <= idx_r - ADDR_W'(1);
    else                              idx_r <= idx_r;
    if (cmd.out_load) begin
      out_removed_r <= removed_r;
      out_status_r  <= status_r;
      out_count_r   <= COUNT_W'(count_r);
    end
  end

  assign out_removed_value = out_removed_r;
  assign out_status        = out_status_r;
  assign out_element_count = out_count_r;

endmodule

>>> sv/plir_ctrl.sv
`timescale 1ns / 1ps
// controller: sequences evaluation, element shifts and result hand-off
// depends on plir_pkg; drives plir_datapath through command signals
module plir_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  plir_pkg::plir_stat_t stat,
  output plir_pkg::plir_cmd_t  cmd
);
  import plir_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_TAKE,
    S_LOOP,
    S_WR,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.stat_load = 1'b1;
        priority if (stat.err) begin
          state_nxt = S_DONE;
        end else if (stat.is_remove) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_POS;
          state_nxt  = S_TAKE;
        end else begin
          cmd.idx_from_count = 1'b1;
          state_nxt          = S_LOOP;
        end
      end
      S_TAKE: begin
        cmd.take_removed = 1'b1;
        cmd.idx_from_pos = 1'b1;
        state_nxt        = S_LOOP;
      end
      S_LOOP: begin
        if (stat.more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = stat.is_remove ? RD_NEXT : RD_PREV;
          state_nxt  = S_WR;
        end else if (stat.is_remove) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          // index has reached the insert position
          cmd.wr_en       = 1'b1;
          cmd.wr_from_val = 1'b1;
          cmd.cnt_inc     = 1'b1;
          state_nxt       = S_DONE;
        end
      end
      S_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_inc = stat.is_remove;
        cmd.idx_dec = !stat.is_remove;
        state_nxt   = S_LOOP;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> sv/positional_list_insert_remove.sv
`timescale 1ns / 1ps
// positional list, insert or remove at an index
// each moved element is read in S_LOOP and written back in S_WR; the element memory is never read and written at once
// a new beat is taken in the cycle after the result is registered, even while it waits
// reset (rst_n low, synchronous) empties the list; memory contents are not cleared
module positional_list_insert_remove #(
  parameter int DEPTH = plir_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  plir_in_if.sink   in_ch,
  plir_out_if.source out_ch
);
  import plir_pkg::*;

  plir_cmd_t  cmd;
  plir_stat_t stat;

  plir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  plir_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_operation      (in_ch.operation),
    .in_item_value     (in_ch.item_value),
    .in_position       (in_ch.position),
    .out_removed_value (out_ch.removed_value),
    .out_status        (out_ch.status),
    .out_element_count (out_ch.element_count)
  );

endmodule

>>> verif/plir_list_checker.sv
`timescale 1ns / 1ps
// result checker for the positional list block: keeps its own copy of the list,
// predicts each result beat and compares it; depends on plir_pkg
module plir_list_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              in_operation,
  input  logic signed [plir_pkg::VAL_W-1:0] in_item_value,
  input  logic [plir_pkg::POS_W-1:0]        in_position,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [plir_pkg::VAL_W-1:0] out_removed_value,
  input  logic [plir_pkg::STAT_W-1:0]       out_status,
  input  logic [plir_pkg::COUNT_W-1:0]      out_element_count,
  output int                                mismatch_count,
  output int                                pending_count
);
  import plir_pkg::*;

  typedef struct {
    logic signed [VAL_W-1:0] removed_value;
    status_t                 status;
    logic [COUNT_W-1:0]      element_count;
  } list_result_t;

  logic signed [VAL_W-1:0] list_vals [DEPTH_DEF];
  int                      list_len;
  int                      errors;
  int                      result_idx;
  list_result_t            expected_results [$];

  function automatic list_result_t apply_list_op(input logic op,
                                                 input logic signed [VAL_W-1:0] val,
                                                 input logic [POS_W-1:0] pos);
    list_result_t res;
    int           p;
    p                 = int'(pos);
    res.removed_value = '0;
    res.status        = ST_OK;
    if (op == OP_INSERT) begin
      // full is checked ahead of the position
      if (list_len >= DEPTH_DEF) begin
        res.status = ST_FULL;
      end else if (p > list_len) begin
        res.status = ST_RANGE;
      end else begin
        for (int i = list_len; i > p; i--) list_vals[i] = list_vals[i-1];
        list_vals[p] = val;
        list_len++;
      end
    end else begin
      if (p >= list_len) begin
        res.status = ST_RANGE;
      end else begin
        res.removed_value = list_vals[p];
        for (int i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
        list_len--;
      end
    end
    res.element_count = COUNT_W'(list_len);
    return res;
  endfunction

  always @(posedge clk) begin : watch_channels
    list_result_t exp_res;
    if (!rst_n) begin
      list_len   = 0;
      errors     = 0;
      result_idx = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result beat: removed_value %0d status %0d count %0d",
                   $time, out_removed_value, out_status, out_element_count);
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_removed_value !== exp_res.removed_value) begin
            $display("%0t result %0d removed_value: expected %0d, actual %0d",
                     $time, result_idx, exp_res.removed_value, out_removed_value);
            errors++;
          end
          if (out_status !== exp_res.status) begin
            $display("%0t result %0d status: expected %0d, actual %0d",
                     $time, result_idx, exp_res.status, out_status);
            errors++;
          end
          if (out_element_count !== exp_res.element_count) begin
            $display("%0t result %0d element_count: expected %0d, actual %0d",
                     $time, result_idx, exp_res.element_count, out_element_count);
            errors++;
          end
        end
        result_idx++;
      end
      if (in_valid && in_ready)
        expected_results.push_back(apply_list_op(in_operation, in_item_value, in_position));
    end
    mismatch_count <= errors;
    pending_count  <= expected_results.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// top of the positional list testbench: clock, reset, request and result traffic
// depends on plir_pkg, plir_ifs, the block and plir_list_checker
module testbench;
  import plir_pkg::*;

  localparam int LIMIT_CYCLES     = 1_000_000;
  localparam int RANDOM_ITEMS     = 1330;
  localparam int PHASE_ITEMS      = 150;
  localparam int TAIL_CYCLES      = 200;
  localparam int LONG_HOLD_START  = 1500;
  localparam int LONG_HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   pending_count;
  int   tracked_len;
  int   burst_left;
  int   rx_cycles;
  bit   long_hold_done;

  plir_in_if  in_ch ();
  plir_out_if out_ch ();

  positional_list_insert_remove #(
    .DEPTH (DEPTH_DEF)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  plir_list_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_operation      (in_ch.operation),
    .in_item_value     (in_ch.item_value),
    .in_position       (in_ch.position),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_removed_value (out_ch.removed_value),
    .out_status        (out_ch.status),
    .out_element_count (out_ch.element_count),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("%0t run did not drain in time", $time);
    $display("Mismatches found");
    $finish;
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // mostly legal positions with the ends favored, some noise over the full field
  function automatic logic [POS_W-1:0] pick_position(input logic op);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return POS_W'($urandom_range(0, 127));
    if (op == OP_INSERT) begin
      if (r < 30) return '0;
      if (r < 50) return POS_W'(tracked_len);
      return POS_W'($urandom_range(0, tracked_len));
    end
    if (tracked_len == 0 || r < 30) return '0;
    if (r < 50) return POS_W'(tracked_len - 1);
    return POS_W'($urandom_range(0, tracked_len - 1));
  endfunction

  task automatic send_item(input logic op, input logic signed [VAL_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.item_value <= val;
    in_ch.position   <= pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // keep a running count so the generator can aim at legal positions
    if (op == OP_INSERT) begin
      if (tracked_len < DEPTH_DEF && int'(pos) <= tracked_len) tracked_len++;
    end else if (int'(pos) < tracked_len) begin
      tracked_len--;
    end
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // result side: random stall segments plus one long hold-off
  initial begin : result_sink
    int mode;
    int seg_len;
    out_ch.ready = 1'b0;
    rx_cycles    = 0;
    long_hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode    = $urandom_range(0, 2);
      seg_len = (mode == 2) ? $urandom_range(1, 8) : $urandom_range(10, 60);
      repeat (seg_len) begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 2) != 0);
          default: out_ch.ready <= 1'b0;
        endcase
        @(posedge clk);
        rx_cycles++;
      end
      if (!long_hold_done && rx_cycles >= LONG_HOLD_START) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        rx_cycles     += LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
    end
  end

  initial begin : request_source
    logic op;
    int   insert_pct;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_INSERT;
    in_ch.item_value = '0;
    in_ch.position   = '0;
    tracked_len      = 0;
    burst_left       = 1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // directed: empty store, head, append, middle, tail, out of range
    send_item(OP_REMOVE, $urandom, 7'd0);
    send_item(OP_REMOVE, $urandom, 7'd127);
    send_item(OP_INSERT, 32'sh12345678, 7'd1);
    send_item(OP_INSERT, 32'sh7fffffff, 7'd0);
    send_item(OP_INSERT, 32'sh80000000, 7'd1);
    // removing the last of two returns that element
    send_item(OP_REMOVE, $urandom, 7'd1);
    send_item(OP_INSERT, -32'sd1, 7'd0);
    send_item(OP_INSERT, 32'sd0, 7'd2);
    send_item(OP_INSERT, 32'sh55555555, 7'd1);
    send_item(OP_INSERT, 32'shaaaaaaaa, 7'd127);
    send_item(OP_REMOVE, $urandom, 7'd4);
    send_item(OP_REMOVE, $urandom, 7'd3);
    send_item(OP_REMOVE, $urandom, 7'd0);
    send_item(OP_REMOVE, $urandom, 7'd1);
    send_item(OP_REMOVE, $urandom, 7'd0);
    send_item(OP_REMOVE, $urandom, 7'd0);

    // random: phases that fill to full, drain to empty, and mix
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / PHASE_ITEMS) % 3)
        0:       insert_pct = 85;
        1:       insert_pct = 15;
        default: insert_pct = 50;
      endcase
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
      send_item(op, pick_value(), pick_position(op));
    end
    in_ch.valid <= 1'b0;

    // let the checker register the last accepted beat before polling
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_count != 0)
      $display("%0t %0d expected results never arrived", $time, pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/plir_pkg.sv
sv/plir_ifs.sv
sv/plir_datapath.sv
sv/plir_ctrl.sv
sv/positional_list_insert_remove.sv
verif/plir_list_checker.sv
verif/testbench.sv
